// ===== rtl/frts_pkg.sv =====
`default_nettype none
package frts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int FLOOR_BITS  = 8;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TAKE = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] DIR_ANY     = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;
    localparam logic [1:0] DIR_DOWN    = 2'd2;
    localparam logic [1:0] DIR_INVALID = 2'd3;
    localparam logic [1:0] DIR_NONE    = 2'd0;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] floor;
        logic [7:0] end_floor;
        logic [1:0] direction;
        logic       same_direction;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] start_floor;
        logic [7:0] dest_floor;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [FLOOR_BITS-1:0] start;
        logic [FLOOR_BITS-1:0] dest;
    } t_entry;

    typedef struct packed {
        logic en;
        logic sel_feed;
    } t_cell_ctl;

    function automatic logic [1:0] travel_dir(input logic [FLOOR_BITS-1:0] s,
                                              input logic [FLOOR_BITS-1:0] d);
        if (d > s) begin
            return DIR_UP;
        end else if (d < s) begin
            return DIR_DOWN;
        end
        return DIR_NONE;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/frts_cell.sv =====
`default_nettype none
module frts_cell
    import frts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_next,
    input  wire t_entry    i_feed,
    output t_entry         o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_entry <= i_ctl.sel_feed ? i_feed : i_next;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== rtl/floor_request_table_scheduler.sv =====
`default_nettype none
// An add writes its entry, then reports; take and find first scan the N stored
// requests, stalling while a result waits on the output register, then report.
// One transaction at a time: a new one is accepted only once the last one has ended.
// The scan rotates the cell ring one entry per cycle past the head cell while no take stalls it.
// Reset (synchronous, active low) empties the table; entry contents are kept.
module floor_request_table_scheduler
    import frts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_entry    w_cell [TABLE_DEPTH];
    t_cell_ctl w_ctl  [TABLE_DEPTH];
    t_entry    w_feed;

    logic            r_busy,  n_busy;
    t_in_item        r_req,   n_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_step,  n_step;
    logic [RES_W-1:0] r_nres,  n_nres;
    logic            r_have_pend, n_have_pend;
    t_entry          r_pend,  n_pend;
    logic            r_found, n_found;
    logic [FLOOR_BITS-1:0] r_best, n_best;
    logic [FLOOR_BITS-1:0] r_bestdist, n_bestdist;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out,   n_out;

    t_entry          w_head;
    logic [1:0]      w_td;
    logic            w_hit, w_ok, w_remove, w_go, w_out_free, w_scan, w_write;
    logic [FLOOR_BITS-1:0] w_dist;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            frts_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_next  (w_cell[(g + 1) % TABLE_DEPTH]),
                .i_feed  (w_feed),
                .o_entry (w_cell[g])
            );
        end
    endgenerate

    assign w_head     = w_cell[0];
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_scan     = r_busy && (r_step != '0);
    assign w_td       = travel_dir(w_head.start, w_head.dest);
    assign w_dist     = (w_head.start >= r_req.floor) ? w_head.start - r_req.floor
                                                      : r_req.floor - w_head.start;

    always_comb begin
        w_hit = (w_head.start == r_req.floor)
             && (r_req.direction == DIR_ANY || w_td == r_req.direction)
             && (r_nres < RES_W'(MAX_RESULTS));
        case (r_req.direction)
            DIR_ANY:  w_ok = 1'b1;
            DIR_UP:   w_ok = w_head.start >= r_req.floor;
            DIR_DOWN: w_ok = w_head.start <= r_req.floor;
            default:  w_ok = 1'b0;
        endcase
        if (r_req.direction != DIR_ANY && r_req.same_direction && w_td != r_req.direction) begin
            w_ok = 1'b0;
        end
    end

    assign w_remove = w_scan && (r_req.op == OP_TAKE) && w_hit;
    assign w_go     = w_scan && !(w_remove && r_have_pend && !w_out_free);
    assign w_write  = r_busy && (r_step == '0) && (r_req.op == OP_ADD) && w_out_free
                   && (r_count < CNT_W'(TABLE_DEPTH));
    assign w_feed   = w_write ? t_entry'{start: r_req.floor, dest: r_req.end_floor} : w_head;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_ctl[i].en       = w_go || (w_write && r_count == CNT_W'(i));
            w_ctl[i].sel_feed = w_write || (!w_remove && r_count == CNT_W'(i + 1));
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_req       = r_req;
        n_count     = r_count;
        n_step      = r_step;
        n_nres      = r_nres;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_found     = r_found;
        n_best      = r_best;
        n_bestdist  = r_bestdist;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (!r_busy) begin
            if (i_in_valid) begin
                n_busy      = 1'b1;
                n_req       = i_in_data;
                n_step      = (i_in_data.op == OP_TAKE || i_in_data.op == OP_FIND) ? r_count : '0;
                n_nres      = '0;
                n_have_pend = 1'b0;
                n_found     = 1'b0;
            end
        end else if (r_step != '0) begin
            if (w_go) begin
                n_step = r_step - 1'b1;
                if (w_remove) begin
                    n_count     = r_count - 1'b1;
                    n_nres      = r_nres + 1'b1;
                    n_have_pend = 1'b1;
                    n_pend      = w_head;
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: ST_OK, start_floor: r_pend.start,
                                  dest_floor: r_pend.dest, last: 1'b0};
                    end
                end
                if (r_req.op == OP_FIND && w_ok && (!r_found || w_dist < r_bestdist)) begin
                    n_found    = 1'b1;
                    n_best     = w_head.start;
                    n_bestdist = w_dist;
                end
            end
        end else if (r_req.op != OP_ADD && r_req.op != OP_TAKE && r_req.op != OP_FIND) begin
            n_busy = 1'b0;
        end else if (w_out_free) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_out       = '{status: ST_NONE, start_floor: '0, dest_floor: '0, last: 1'b1};
            case (r_req.op)
                OP_ADD: begin
                    n_out.status = w_write ? ST_OK : ST_FULL;
                    if (w_write) begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_TAKE: begin
                    if (r_have_pend) begin
                        n_out = '{status: ST_OK, start_floor: r_pend.start,
                                  dest_floor: r_pend.dest, last: 1'b1};
                    end
                    n_have_pend = 1'b0;
                end
                OP_FIND: begin
                    if (r_found) begin
                        n_out.status      = ST_OK;
                        n_out.start_floor = r_best;
                    end
                end
                default: begin
                    n_out_valid = r_out_valid && !i_out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_step      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_step      <= n_step;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_nres     <= n_nres;
        r_pend     <= n_pend;
        r_found    <= n_found;
        r_best     <= n_best;
        r_bestdist <= n_bestdist;
        r_out      <= n_out;
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
